// File: design/stes_pkg.sv
`timescale 1ns / 1ps

package stes_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 10;
  localparam int REQ_W = 2;
  localparam int PC_W = 3;

  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  localparam logic [PC_W-1:0] STEP_WAIT    = 3'd0;
  localparam logic [PC_W-1:0] STEP_INIT_L  = 3'd1;
  localparam logic [PC_W-1:0] STEP_PROBE_L = 3'd2;
  localparam logic [PC_W-1:0] STEP_CMP_L   = 3'd3;
  localparam logic [PC_W-1:0] STEP_INIT_R  = 3'd4;
  localparam logic [PC_W-1:0] STEP_PROBE_R = 3'd5;
  localparam logic [PC_W-1:0] STEP_CMP_R   = 3'd6;
  localparam logic [PC_W-1:0] STEP_EMIT    = 3'd7;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_QUERY,
    COND_DONE,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    logic            take;
    logic            init;
    logic            save;
    logic            probe;
    logic            cmp;
    logic            go_left;
    logic            emit;
    logic            stay;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic acc_query;
    logic done;
    logic out_free;
  } status_t;

  function automatic ctl_t ucode_rom(input logic [PC_W-1:0] pc);
    ctl_t w;
    w = '0;
    w.cond = COND_ALWAYS;
    w.target = STEP_WAIT;
    unique case (pc)
      STEP_WAIT: begin
        w.take = 1'b1;
        w.stay = 1'b1;
        w.cond = COND_QUERY;
        w.target = STEP_INIT_L;
      end
      STEP_INIT_L: begin
        w.init = 1'b1;
        w.target = STEP_PROBE_L;
      end
      STEP_PROBE_L: begin
        w.probe = 1'b1;
        w.cond = COND_DONE;
        w.target = STEP_INIT_R;
      end
      STEP_CMP_L: begin
        w.cmp = 1'b1;
        w.go_left = 1'b1;
        w.target = STEP_PROBE_L;
      end
      STEP_INIT_R: begin
        w.init = 1'b1;
        w.save = 1'b1;
        w.target = STEP_PROBE_R;
      end
      STEP_PROBE_R: begin
        w.probe = 1'b1;
        w.cond = COND_DONE;
        w.target = STEP_EMIT;
      end
      STEP_CMP_R: begin
        w.cmp = 1'b1;
        w.target = STEP_PROBE_R;
      end
      STEP_EMIT: begin
        w.emit = 1'b1;
        w.stay = 1'b1;
        w.cond = COND_OUT_FREE;
        w.target = STEP_WAIT;
      end
      default: begin
        w.target = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

// File: design/stes_if.sv
`timescale 1ns / 1ps

interface stes_in_if import stes_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [REQ_W-1:0]           req_type;
  logic signed [VALUE_W-1:0]  item_value;

  modport source (output valid, output req_type, output item_value, input ready);
  modport sink (input valid, input req_type, input item_value, output ready);
endinterface

interface stes_out_if import stes_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [INDEX_W-1:0] first_index;
  logic [INDEX_W-1:0] last_index;

  modport source (output valid, output found, output first_index, output last_index,
                  input ready);
  modport sink (input valid, input found, input first_index, input last_index,
                output ready);
endinterface

// File: design/sorted_table_equal_range_search_core.sv
`timescale 1ns / 1ps
// Sorted table with equal-range search.
// Channel item (sink): req_type 0 clears the table, 1 appends item_value as
// the next entry (dropped when the table is full), 2 queries item_value;
// code 3 is dropped. Channel result (source): one beat per query with found,
// first_index and last_index (both zero when the value is absent).
// Clears and appends are taken in the wait step, which stays ready for the
// next item. A query holds the block from its accept through a first-index
// search, a last-index search and the emit step, which registers the result
// beat, before the next item can be taken. Each binary search makes at most
// floor(log2(n)) + 1 probes for n filled entries. Each probe is a probe step
// and a compare step, since the table memory has a single registered read
// port; the microcode program steps through both searches one probe at a
// time and takes one item at a time.
// Reset empties the table and the program restarts at its wait step; the
// memory contents are not cleared. The result is held in an output register;
// while the receiver stalls, the pending beat holds there, clears and appends
// are still taken, and the next query waits in its emit step, taking no new
// item, until the pending beat is accepted.
module sorted_table_equal_range_search_core import stes_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  stes_in_if.sink    item,
  stes_out_if.source result
);

  ctl_t    ctl;
  status_t status;

  stes_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctl    (ctl)
  );

  stes_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .status (status),
    .item   (item),
    .result (result)
  );

endmodule

// File: design/stes_seq.sv
`timescale 1ns / 1ps

module stes_seq import stes_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctl_t    ctl
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            cond_true;

  assign ctl = ucode_rom(pc);

  always_comb begin
    unique case (ctl.cond)
      COND_ALWAYS:   cond_true = 1'b1;
      COND_QUERY:    cond_true = status.acc_query;
      COND_DONE:     cond_true = status.done;
      COND_OUT_FREE: cond_true = status.out_free;
      default:       cond_true = 1'b1;
    endcase
  end

  always_comb begin
    if (cond_true) begin
      pc_next = ctl.target;
    end else if (ctl.stay) begin
      pc_next = pc;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: design/stes_dp.sv
`timescale 1ns / 1ps

module stes_dp import stes_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  ctl_t       ctl,
  output status_t    status,
  stes_in_if.sink    item,
  stes_out_if.source result
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];
  logic signed [VALUE_W-1:0] rd_data;
  logic signed [VALUE_W-1:0] key;
  logic [CW-1:0]             count;
  logic [CW-1:0]             lo;
  logic [CW-1:0]             hip1;
  logic [AW-1:0]             mid;
  logic [CW:0]               mid_sum;
  logic [CW-1:0]             mid_inc;
  logic [AW-1:0]             hit_idx;
  logic                      hit_v;
  logic [AW-1:0]             first_idx;
  logic                      first_v;
  logic                      fire;
  logic                      out_free;

  assign item.ready = ctl.take;
  assign fire = item.valid && item.ready;
  assign out_free = !result.valid || result.ready;

  assign status.acc_query = fire && (item.req_type == REQ_QUERY);
  assign status.done = (lo >= hip1);
  assign status.out_free = out_free;

  assign mid_sum = {1'b0, lo} + {1'b0, hip1} - (CW+1)'(1);
  assign mid_inc = CW'(mid) + CW'(1);

  always_ff @(posedge clk) begin
    if (fire && item.req_type == REQ_APPEND && count < CW'(TABLE_DEPTH)) begin
      mem[count[AW-1:0]] <= item.item_value;
    end
    if (ctl.probe) begin
      rd_data <= mem[mid_sum[AW:1]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      if (item.req_type == REQ_CLEAR) begin
        count <= '0;
      end else if (item.req_type == REQ_APPEND && count < CW'(TABLE_DEPTH)) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (status.acc_query) begin
      key <= item.item_value;
    end
    if (ctl.probe) begin
      mid <= mid_sum[AW:1];
    end
    if (ctl.save) begin
      first_idx <= hit_idx;
      first_v <= hit_v;
    end
    if (ctl.init) begin
      lo <= '0;
      hip1 <= count;
      hit_v <= 1'b0;
    end else if (ctl.cmp) begin
      if (rd_data == key) begin
        hit_idx <= mid;
        hit_v <= 1'b1;
        if (ctl.go_left) begin
          hip1 <= CW'(mid);
        end else begin
          lo <= mid_inc;
        end
      end else if (rd_data < key) begin
        lo <= mid_inc;
      end else begin
        hip1 <= CW'(mid);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (ctl.emit && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit && out_free) begin
      result.found <= first_v && hit_v;
      result.first_index <= (first_v && hit_v) ? INDEX_W'(first_idx) : '0;
      result.last_index <= (first_v && hit_v) ? INDEX_W'(hit_idx) : '0;
    end
  end

endmodule
